// ===== rtl/core/ptbd_pkg.sv =====
// shared types, codes and helpers for the pulse train byte decoder
package ptbd_pkg;

    // widths of the payload
    localparam int unsigned LEN_W  = 36;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned REM_W  = 3;

    // tag byte layout
    localparam logic [BYTE_W-1:0] TAG_NIBBLE_MASK = 8'h0f;

    // record kinds from the tag
    typedef enum logic [1:0] {
        KIND_POS   = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_SPLIT = 2'd2,
        KIND_NEG   = 2'd3
    } t_kind;

    // two's complement level codes
    localparam logic signed [1:0] LVL_POS  = 2'sb01;
    localparam logic signed [1:0] LVL_ZERO = 2'sb00;
    localparam logic signed [1:0] LVL_NEG  = 2'sb11;

    // result status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // one parsed record handed from front to back
    typedef struct packed {
        logic [LEN_W-1:0] len;
        t_kind            kind;
        logic             err;
    } t_rec;

    // back end phase
    typedef enum logic {
        BK_FIRST  = 1'b0,
        BK_SECOND = 1'b1
    } t_back_state;

    // level after the optional inversion
    function automatic logic signed [1:0] level_code(input logic signed [1:0] lvl,
                                                     input logic inv);
        logic signed [1:0] res;
        res = inv ? -lvl : lvl;
        return res;
    endfunction

endpackage

// ===== rtl/core/pulse_train_byte_decoder.sv =====
// top level of the pulse train byte decoder
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------------
//  in      | i_in_valid / o_in_ready    | i_data_byte, i_chunk_end
//  out     | o_out_valid / i_out_ready  | o_pulse_length, o_pulse_level, o_status,
//          |                            | o_last_of_run
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_invert_levels
//
//  one input beat per cycle while the record queue has room
//  a record leaves as one output beat, a split record as two beats, the second loaded
//  as soon as the first is taken, so sustained rate is set by the single output register of the back end
//  a result is shown once its closing byte has passed the record queue and the back end output register
//  reset is synchronous, active low, clears decode state and the invert setting
//  output stalls back up through the queue of P_QUEUE_DEPTH records to o_in_ready
module pulse_train_byte_decoder #(
    parameter int unsigned P_QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_chunk_end,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [35:0]       o_pulse_length,
    output logic signed [1:0] o_pulse_level,
    output logic              o_status,
    output logic              o_last_of_run,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_invert_levels
);
    import ptbd_pkg::*;

    logic r_invert;
    logic w_push, w_pop, w_full, w_empty;
    t_rec w_push_rec, w_pop_rec;

    // invert setting register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
        end else if (i_cfg_valid) begin
            r_invert <= i_cfg_invert_levels;
        end
    end

    ptbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_chunk_end (i_chunk_end),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_rec       (w_push_rec)
    );

    ptbd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .o_full  (w_full),
        .o_empty (w_empty),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec)
    );

    ptbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_invert       (r_invert),
        .i_q_empty      (w_empty),
        .i_rec          (w_pop_rec),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pulse_length (o_pulse_length),
        .o_pulse_level  (o_pulse_level),
        .o_status       (o_status),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ===== rtl/core/ptbd_front.sv =====
// front end: takes bytes, assembles records and flags chunks cut short
module ptbd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_chunk_end,
    input  logic                   i_q_full,
    output logic                   o_push,
    output ptbd_pkg::t_rec         o_rec
);
    import ptbd_pkg::*;

    logic [REM_W-1:0] r_rem, n_rem;
    logic [LEN_W-1:0] r_acc, n_acc;
    t_kind            r_kind, n_kind;
    logic             w_accept;
    logic [LEN_W-1:0] w_acc_shift;
    logic [REM_W-1:0] w_rem_dec;

    assign o_in_ready  = !i_q_full;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_acc_shift = {r_acc[LEN_W-BYTE_W-1:0], i_data_byte};
    assign w_rem_dec   = r_rem - REM_W'(1);

    // record assembly
    always_comb begin
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_kind    = r_kind;
        o_push    = 1'b0;
        o_rec.len  = w_acc_shift;
        o_rec.kind = r_kind;
        o_rec.err  = 1'b0;
        if (w_accept) begin
            if (r_rem == '0) begin
                // tag byte
                n_kind = t_kind'(i_data_byte[7:6]);
                n_rem  = REM_W'(i_data_byte[5:4]) + REM_W'(1);
                n_acc  = LEN_W'(i_data_byte & TAG_NIBBLE_MASK);
                if (i_chunk_end) begin
                    n_rem     = '0;
                    o_push    = 1'b1;
                    o_rec.err = 1'b1;
                end
            end else begin
                // length byte
                n_acc = w_acc_shift;
                n_rem = w_rem_dec;
                if (w_rem_dec == '0) begin
                    o_push = 1'b1;
                end else if (i_chunk_end) begin
                    n_rem     = '0;
                    o_push    = 1'b1;
                    o_rec.err = 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_kind <= KIND_POS;
        end else begin
            r_rem  <= n_rem;
            r_kind <= n_kind;
        end
        r_acc <= n_acc;
    end

    // at most four length bytes follow a tag
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= REM_W'(4))
        else $error("byte count out of range");

    // a cut-short chunk always leaves the front waiting for a tag
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_rec.err) |=> (r_rem == '0))
        else $error("front not idle after error");

endmodule

// ===== rtl/core/ptbd_queue.sv =====
// small record queue between the front and back ends
module ptbd_queue #(
    parameter int unsigned P_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptbd_pkg::t_rec i_rec,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output ptbd_pkg::t_rec o_rec
);
    import ptbd_pkg::*;

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);

    t_rec             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/ptbd_back.sv =====
// back end: turns records into pulse beats, splitting kind 2 records
module ptbd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_invert,
    input  logic                   i_q_empty,
    input  ptbd_pkg::t_rec         i_rec,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [35:0]            o_pulse_length,
    output logic signed [1:0]      o_pulse_level,
    output logic                   o_status,
    output logic                   o_last_of_run
);
    import ptbd_pkg::*;

    t_back_state       r_state, n_state;
    logic              r_valid, n_valid;
    logic [LEN_W-1:0]  r_len, n_len;
    logic signed [1:0] r_lvl, n_lvl;
    logic              r_stat, n_stat;
    logic              r_last, n_last;
    logic [LEN_W-1:0]  r_rest, n_rest;
    logic              w_load_ok;
    logic [LEN_W-1:0]  w_half;

    assign w_load_ok = !r_valid || i_out_ready;
    assign w_half    = i_rec.len >> 1;

    // next phase
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_FIRST: begin
                if (w_load_ok && !i_q_empty && !i_rec.err && i_rec.kind == KIND_SPLIT) begin
                    n_state = BK_SECOND;
                end
            end
            BK_SECOND: begin
                if (w_load_ok) begin
                    n_state = BK_FIRST;
                end
            end
            default: n_state = BK_FIRST;
        endcase
    end

    // output register loading
    always_comb begin
        o_pop   = 1'b0;
        n_valid = r_valid && !i_out_ready;
        n_len   = r_len;
        n_lvl   = r_lvl;
        n_stat  = r_stat;
        n_last  = r_last;
        n_rest  = r_rest;
        unique case (r_state)
            BK_SECOND: begin
                if (w_load_ok) begin
                    n_valid = 1'b1;
                    n_len   = r_rest;
                    n_lvl   = level_code(LVL_POS, i_invert);
                    n_stat  = STAT_OK;
                    n_last  = 1'b1;
                end
            end
            default: begin
                if (w_load_ok && !i_q_empty) begin
                    o_pop   = 1'b1;
                    n_valid = 1'b1;
                    n_stat  = STAT_OK;
                    n_last  = 1'b1;
                    n_len   = i_rec.len;
                    n_rest  = i_rec.len - w_half;
                    if (i_rec.err) begin
                        n_len  = '0;
                        n_lvl  = LVL_ZERO;
                        n_stat = STAT_ERR;
                    end else begin
                        unique case (i_rec.kind)
                            KIND_POS:  n_lvl = level_code(LVL_POS, i_invert);
                            KIND_ZERO: n_lvl = LVL_ZERO;
                            KIND_NEG:  n_lvl = level_code(LVL_NEG, i_invert);
                            KIND_SPLIT: begin
                                n_len  = w_half;
                                n_lvl  = level_code(LVL_NEG, i_invert);
                                n_last = 1'b0;
                            end
                            default: n_lvl = LVL_ZERO;
                        endcase
                    end
                end
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_len  <= n_len;
        r_lvl  <= n_lvl;
        r_stat <= n_stat;
        r_last <= n_last;
        r_rest <= n_rest;
    end

    assign o_out_valid    = r_valid;
    assign o_pulse_length = r_len;
    assign o_pulse_level  = r_lvl;
    assign o_status       = r_stat;
    assign o_last_of_run  = r_last;

    // the second half of a split is shown right after the first is taken
    a_split_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_ready && !r_last) |=> (r_valid && r_last && r_stat == STAT_OK))
        else $error("split second half missing");

    // an error beat carries no length and closes the run
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_stat == STAT_ERR) |-> (r_len == '0 && r_last && r_lvl == LVL_ZERO))
        else $error("malformed error beat");

endmodule

// ===== test/pulse_train_byte_decoder_checker.sv =====
// checker for the pulse train byte decoder: watches the channels, predicts pulses, compares
module pulse_train_byte_decoder_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_chunk_end,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [35:0]       i_pulse_length,
    input  logic [1:0]        i_pulse_level,
    input  logic              i_status,
    input  logic              i_last_of_run,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_invert_levels,
    input  logic              i_done,
    output int                o_pending,
    output int                o_fail_count,
    output int                o_beats_checked,
    output int                o_chunk_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import ptbd_pkg::*;

    // one expected output beat
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [1:0]       lvl;
        logic             st;
        logic             last;
    } t_pulse_due;

    t_pulse_due       pulses_due[$];
    logic [REM_W-1:0] bytes_left;
    logic [LEN_W-1:0] len_acc;
    t_kind            cur_kind;
    logic             invert_now;
    logic             closed;
    int               fails;
    int               checked;
    int               chunk_errs;

    initial begin
        fails      = 0;
        checked    = 0;
        chunk_errs = 0;
        closed     = 1'b0;
        o_pending       = 0;
        o_fail_count    = 0;
        o_beats_checked = 0;
        o_chunk_errors  = 0;
    end

    // level after the invert setting, sign given as -1, 0 or +1
    function automatic logic [1:0] driven_level(input int sign);
        int s;
        s = invert_now ? -sign : sign;
        if (s > 0) begin
            return LVL_POS;
        end else if (s < 0) begin
            return LVL_NEG;
        end
        return LVL_ZERO;
    endfunction

    function automatic t_pulse_due make_pulse(input logic [LEN_W-1:0] len, input logic [1:0] lvl,
                                              input logic st, input logic last);
        t_pulse_due p;
        p.len  = len;
        p.lvl  = lvl;
        p.st   = st;
        p.last = last;
        return p;
    endfunction

    // chunk ended inside a record
    task automatic flag_truncated();
        bytes_left = '0;
        len_acc    = '0;
        pulses_due.push_back(make_pulse('0, LVL_ZERO, STAT_ERR, 1'b1));
    endtask

    // advance the record parser by one byte and queue the pulses it closes
    task automatic decode_byte(input logic [7:0] b, input logic e);
        logic [LEN_W-1:0] total;
        logic [LEN_W-1:0] half;
        if (bytes_left == '0) begin
            cur_kind   = t_kind'(b[7:6]);
            bytes_left = {1'b0, b[5:4]} + 3'd1;
            len_acc    = {{(LEN_W-BYTE_W){1'b0}}, b & TAG_NIBBLE_MASK};
            if (e) begin
                flag_truncated();
            end
        end else begin
            len_acc    = {len_acc[LEN_W-BYTE_W-1:0], b};
            bytes_left = bytes_left - 3'd1;
            if (bytes_left != '0) begin
                if (e) begin
                    flag_truncated();
                end
            end else begin
                total   = len_acc;
                len_acc = '0;
                case (cur_kind)
                    KIND_POS: begin
                        pulses_due.push_back(make_pulse(total, driven_level(1), STAT_OK, 1'b1));
                    end
                    KIND_ZERO: begin
                        pulses_due.push_back(make_pulse(total, driven_level(0), STAT_OK, 1'b1));
                    end
                    KIND_SPLIT: begin
                        half = total >> 1;
                        pulses_due.push_back(make_pulse(half, driven_level(-1), STAT_OK, 1'b0));
                        pulses_due.push_back(make_pulse(total - half, driven_level(1), STAT_OK,
                                                        1'b1));
                    end
                    default: begin
                        pulses_due.push_back(make_pulse(total, driven_level(-1), STAT_OK, 1'b1));
                    end
                endcase
            end
        end
    endtask

    // compare one output beat with the oldest expectation
    task automatic check_beat();
        t_pulse_due want;
        logic       bad;
        bad = 1'b0;
        if (pulses_due.size() == 0) begin
            $display("%0t: output beat with nothing expected (len %h lvl %b st %b last %b)",
                     $time, i_pulse_length, i_pulse_level, i_status, i_last_of_run);
            fails++;
        end else begin
            want = pulses_due.pop_front();
            checked++;
            if (i_status == STAT_ERR) begin
                chunk_errs++;
            end
            if (i_pulse_length !== want.len) begin
                $display("%0t: pulse_length expected %h, got %h", $time, want.len, i_pulse_length);
                bad = 1'b1;
            end
            if (i_pulse_level !== want.lvl) begin
                $display("%0t: pulse_level expected %b, got %b", $time, want.lvl, i_pulse_level);
                bad = 1'b1;
            end
            if (i_status !== want.st) begin
                $display("%0t: status expected %b, got %b", $time, want.st, i_status);
                bad = 1'b1;
            end
            if (i_last_of_run !== want.last) begin
                $display("%0t: last_of_run expected %b, got %b", $time, want.last, i_last_of_run);
                bad = 1'b1;
            end
            if (bad) begin
                fails++;
            end
        end
    endtask

    // sample every channel at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bytes_left = '0;
            len_acc    = '0;
            cur_kind   = KIND_POS;
            invert_now = 1'b0;
            pulses_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                invert_now = i_cfg_invert_levels;
            end
            if (i_out_valid && i_out_ready) begin
                check_beat();
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_data_byte, i_chunk_end);
            end
        end
        // anything still owed at the end is a failure
        if (i_done && !closed) begin
            closed = 1'b1;
            if (pulses_due.size() != 0) begin
                $display("%0t: %0d expected beats never arrived", $time, pulses_due.size());
                fails += pulses_due.size();
            end
        end
        o_pending       <= pulses_due.size();
        o_fail_count    <= fails;
        o_beats_checked <= checked;
        o_chunk_errors  <= chunk_errs;
    end

endmodule

// ===== test/tb_pulse_train_byte_decoder.sv =====
// testbench top for the pulse train byte decoder: stimulus, handshakes and verdict
module tb_pulse_train_byte_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import ptbd_pkg::*;

    logic              i_clk;
    logic              i_rst_n             = 1'b0;
    logic              i_in_valid          = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_data_byte         = 8'h00;
    logic              i_chunk_end         = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready         = 1'b0;
    logic [35:0]       o_pulse_length;
    logic signed [1:0] o_pulse_level;
    logic              o_status;
    logic              o_last_of_run;
    logic              i_cfg_valid         = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_invert_levels = 1'b0;
    logic              checks_closed       = 1'b0;

    int pending;
    int fail_count;
    int beats_checked;
    int chunk_errors;
    int bytes_sent   = 0;
    bit hold_done    = 1'b0;

    // hand-picked opening bytes: {chunk_end, data_byte}
    logic [8:0] directed_bytes [23] = '{
        // zero length at positive level
        9'h000, 9'h000,
        // longest length at level zero, four bytes of ones
        9'h07f, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,
        // split record of length one, first half is zero
        9'h080, 9'h001,
        // split record of length zero
        9'h080, 9'h000,
        // four length bytes, chunk ends on the closing byte
        9'h0b5, 9'h012, 9'h034, 9'h056, 9'h179,
        // chunk ends on a tag
        9'h1c3,
        // chunk ends on a length byte that is not the last
        9'h0da, 9'h1aa,
        // negative level, three length bytes
        9'h0e0, 9'h000, 9'h000, 9'h001
    };

    pulse_train_byte_decoder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_chunk_end         (i_chunk_end),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_pulse_length      (o_pulse_length),
        .o_pulse_level       (o_pulse_level),
        .o_status            (o_status),
        .o_last_of_run       (o_last_of_run),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_invert_levels (i_cfg_invert_levels)
    );

    pulse_train_byte_decoder_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_chunk_end         (i_chunk_end),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_pulse_length      (o_pulse_length),
        .i_pulse_level       (o_pulse_level),
        .i_status            (o_status),
        .i_last_of_run       (o_last_of_run),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_invert_levels (i_cfg_invert_levels),
        .i_done              (checks_closed),
        .o_pending           (pending),
        .o_fail_count        (fail_count),
        .o_beats_checked     (beats_checked),
        .o_chunk_errors      (chunk_errors)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("[pulse_train_byte_decoder] ERROR");
        $finish;
    end

    // receiver: random stalls, a calm stretch and one long hold-off once 600 bytes are sent
    initial begin
        forever begin
            @(posedge i_clk);
            if (!hold_done && bytes_sent >= 600) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (150) @(posedge i_clk);
            end else if (bytes_sent >= 150 && bytes_sent < 350) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // length bytes lean towards all zeros and all ones now and then
    function automatic logic [7:0] pick_byte();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return 8'h00;
        end else if (roll == 1) begin
            return 8'hff;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one byte, with a random gap first, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic e);
        if (!(bytes_sent >= 700 && bytes_sent < 850) && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 19);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_chunk_end <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // a whole record, a record cut short by the chunk end, or a stray byte
    task automatic send_random_record();
        logic [7:0]  tag;
        int unsigned roll;
        int unsigned span;
        int unsigned cut;
        roll = $urandom_range(0, 99);
        tag  = pick_byte();
        span = tag[5:4] + 1;
        if (roll < 8) begin
            send_byte(pick_byte(), $urandom_range(0, 2) == 0);
        end else if (roll < 18) begin
            cut = $urandom_range(0, span - 1);
            for (int k = 0; k <= cut; k++) begin
                send_byte((k == 0) ? tag : pick_byte(), k == cut);
            end
        end else begin
            send_byte(tag, 1'b0);
            for (int k = 1; k <= span; k++) begin
                send_byte(pick_byte(), (k == span) && ($urandom_range(0, 3) == 0));
            end
        end
    endtask

    // sender has stopped: wait until every pulse is out and the pipeline settles
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_invert(input logic v);
        i_cfg_valid         <= 1'b1;
        i_cfg_invert_levels <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            send_random_record();
        end
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    // stimulus and verdict
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[n]) begin
            send_byte(directed_bytes[n][7:0], directed_bytes[n][8]);
        end
        i_in_valid <= 1'b0;
        wait_drained();

        write_invert(1'b1);
        run_phase(350);
        write_invert(1'b0);
        run_phase(350);
        write_invert(1'b1);
        run_phase(350);

        checks_closed <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("covered %0d bytes: directed records, then random phases with invert on, off, on",
                 bytes_sent);
        $display("%0d result beats compared, %0d of them truncated-chunk errors",
                 beats_checked, chunk_errors);
        if (fail_count == 0) begin
            $display("[pulse_train_byte_decoder] OK");
        end else begin
            $display("[pulse_train_byte_decoder] ERROR");
        end
        $finish;
    end

endmodule
